@@ hw/rtl/ucs_pkg.sv @@
// Shared types, codes and byte-class functions for the URI component splitter.
// No dependencies; imported by every module of the block.
package ucs_pkg;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] part_code;
    logic       run_last;
    logic       uri_done;
    logic [2:0] status;
    logic       has_authority;
    logic       has_query;
    logic       has_fragment;
  } out_item_t;

  // Up to two result items per input item.
  typedef struct packed {
    logic [1:0] count;
    out_item_t  first;
    out_item_t  second;
  } res_pair_t;

  typedef enum logic [2:0] {
    PH_SCHEME = 3'd0,
    PH_COLON  = 3'd1,
    PH_HELD   = 3'd2,
    PH_AUTH   = 3'd3,
    PH_PATH   = 3'd4,
    PH_QUERY  = 3'd5,
    PH_FRAG   = 3'd6
  } phase_t;

  localparam logic [2:0] PART_SCHEME = 3'd0;
  localparam logic [2:0] PART_AUTH   = 3'd1;
  localparam logic [2:0] PART_PATH   = 3'd2;
  localparam logic [2:0] PART_QUERY  = 3'd3;
  localparam logic [2:0] PART_FRAG   = 3'd4;
  localparam logic [2:0] PART_SEP    = 3'd5;

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_SCHEME_START = 3'd1;
  localparam logic [2:0] ST_SCHEME_CHAR  = 3'd2;
  localparam logic [2:0] ST_NO_COLON     = 3'd3;
  localparam logic [2:0] ST_BAD_AUTH     = 3'd4;
  localparam logic [2:0] ST_BAD_PATH     = 3'd5;
  localparam logic [2:0] ST_BAD_QUERY    = 3'd6;
  localparam logic [2:0] ST_BAD_FRAG     = 3'd7;

  localparam logic [2:0] FLAG_AUTH  = 3'b001;
  localparam logic [2:0] FLAG_QUERY = 3'b010;
  localparam logic [2:0] FLAG_FRAG  = 3'b100;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_QMARK   = 8'h3F;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_TILDE   = 8'h7E;
  localparam logic [7:0] CH_AT      = 8'h40;

  // Outcome of one byte in the authority, path, query or fragment phase.
  typedef struct packed {
    phase_t     phase;
    logic [1:0] esc;
    logic [2:0] err;
    logic [2:0] flags;
    logic [2:0] part;
  } body_t;

  function automatic logic alpha_byte(input logic [7:0] c);
    return (c inside {[8'h41:8'h5A], [8'h61:8'h7A]});
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c inside {[8'h30:8'h39]});
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || (c inside {[8'h41:8'h46], [8'h61:8'h66]});
  endfunction

  function automatic logic scheme_byte(input logic [7:0] c);
    return alpha_byte(c) || is_digit(c) || (c inside {8'h2B, 8'h2D, 8'h2E});
  endfunction

  // unreserved, sub-delims, ':' and '@'
  function automatic logic pchar_byte(input logic [7:0] c);
    return alpha_byte(c) || is_digit(c) ||
           (c inside {8'h2D, 8'h2E, 8'h5F, CH_TILDE, 8'h21, 8'h24, 8'h26, 8'h27,
                      8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h3B, 8'h3D,
                      CH_COLON, CH_AT});
  endfunction

  function automatic logic char_ok(input logic [7:0] c, input phase_t ph);
    logic ok;
    case (ph)
      PH_AUTH: ok = pchar_byte(c);
      PH_PATH: ok = pchar_byte(c) || (c == CH_SLASH);
      default: ok = pchar_byte(c) || (c == CH_SLASH) || (c == CH_QMARK);
    endcase
    return ok;
  endfunction

  function automatic logic [2:0] err_of(input phase_t ph);
    logic [2:0] e;
    case (ph)
      PH_AUTH:  e = ST_BAD_AUTH;
      PH_PATH:  e = ST_BAD_PATH;
      PH_QUERY: e = ST_BAD_QUERY;
      PH_FRAG:  e = ST_BAD_FRAG;
      default:  e = ST_OK;
    endcase
    return e;
  endfunction

  function automatic logic [2:0] part_of(input phase_t ph);
    logic [2:0] p;
    case (ph)
      PH_AUTH:  p = PART_AUTH;
      PH_QUERY: p = PART_QUERY;
      PH_FRAG:  p = PART_FRAG;
      default:  p = PART_PATH;
    endcase
    return p;
  endfunction

  function automatic logic in_body(input phase_t ph);
    return (ph == PH_AUTH) || (ph == PH_PATH) || (ph == PH_QUERY) || (ph == PH_FRAG);
  endfunction

  function automatic out_item_t make_item(input logic [7:0] b, input logic [2:0] part);
    out_item_t r;
    r          = '0;
    r.out_byte = b;
    r.part_code = part;
    return r;
  endfunction

  function automatic body_t body_step(input logic [7:0] b, input phase_t ph,
                                      input logic [1:0] esc, input logic strict);
    body_t r;
    logic  ends;
    r.phase = ph;
    r.esc   = esc;
    r.err   = ST_OK;
    r.flags = '0;
    r.part  = part_of(ph);
    ends = ((b == CH_HASH) && (ph != PH_FRAG)) ||
           ((b == CH_QMARK) && ((ph == PH_AUTH) || (ph == PH_PATH))) ||
           ((b == CH_SLASH) && (ph == PH_AUTH));
    if (ends) begin
      // a delimiter cuts off any open escape
      if ((esc != 2'd0) && strict) begin
        r.err = err_of(ph);
      end
      r.esc = 2'd0;
      if (b == CH_SLASH) begin
        r.phase = PH_PATH;
        r.part  = PART_PATH;
      end else if (b == CH_QMARK) begin
        r.phase = PH_QUERY;
        r.flags = FLAG_QUERY;
        r.part  = PART_SEP;
      end else begin
        r.phase = PH_FRAG;
        r.flags = FLAG_FRAG;
        r.part  = PART_SEP;
      end
    end else if (esc != 2'd0) begin
      if (is_hex(b)) begin
        r.esc = esc - 2'd1;
      end else begin
        if (strict) begin
          r.err = err_of(ph);
        end
        r.esc = 2'd0;
      end
    end else if (b == CH_PERCENT) begin
      r.esc = 2'd2;
    end else if (strict && !char_ok(b, ph)) begin
      r.err = err_of(ph);
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/ucs_classifier.sv @@
// Per-byte classifier: parse state, strict-mode register and the result pair
// for the byte in the input register. Depends on ucs_pkg.
module ucs_classifier
  import ucs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_write,
  input  logic      cfg_data,
  input  logic      advance,
  input  in_item_t  item,
  output res_pair_t res
);

  logic       strict_mode;
  phase_t     phase, phase_next;
  logic [1:0] escape_pending, escape_pending_next;
  logic [2:0] first_error, first_error_next;
  logic       scheme_seen, scheme_seen_next;
  logic [2:0] part_flags, part_flags_next;

  always_comb begin
    logic [7:0] b;
    logic       fin;
    logic       run_body;
    logic       body_second;
    phase_t     bph;
    body_t      bd;
    out_item_t  r0, r1;
    logic [1:0] n;

    b    = item.text_byte;
    fin  = item.final_byte;
    r0   = '0;
    r1   = '0;
    n    = 2'd0;
    run_body    = 1'b0;
    body_second = 1'b0;
    bph  = in_body(phase) ? phase : PH_PATH;

    phase_next          = phase;
    escape_pending_next = escape_pending;
    first_error_next    = first_error;
    scheme_seen_next    = scheme_seen;
    part_flags_next     = part_flags;

    case (phase)
      PH_SCHEME: begin
        n  = 2'd1;
        if (b == CH_COLON) begin
          if (!scheme_seen && (first_error_next == ST_OK)) begin
            first_error_next = ST_SCHEME_START;
          end
          phase_next = PH_COLON;
          r0 = make_item(b, PART_SEP);
        end else begin
          if (first_error_next == ST_OK) begin
            if (!scheme_seen && !alpha_byte(b)) begin
              first_error_next = ST_SCHEME_START;
            end else if (scheme_seen && !scheme_byte(b)) begin
              first_error_next = ST_SCHEME_CHAR;
            end
          end
          scheme_seen_next = 1'b1;
          r0 = make_item(b, PART_SCHEME);
        end
      end
      PH_COLON: begin
        // hold a lone slash until the next byte tells "//" from a path
        if ((b == CH_SLASH) && !fin) begin
          phase_next = PH_HELD;
        end else begin
          run_body = 1'b1;
        end
      end
      PH_HELD: begin
        n = 2'd2;
        if (b == CH_SLASH) begin
          r0 = make_item(CH_SLASH, PART_SEP);
          r1 = make_item(b, PART_SEP);
          part_flags_next = part_flags | FLAG_AUTH;
          phase_next = PH_AUTH;
        end else begin
          r0 = make_item(CH_SLASH, PART_PATH);
          run_body    = 1'b1;
          body_second = 1'b1;
        end
      end
      default: begin
        run_body = 1'b1;
      end
    endcase

    bd = body_step(b, bph, escape_pending, strict_mode);
    if (run_body) begin
      phase_next          = bd.phase;
      escape_pending_next = bd.esc;
      part_flags_next     = part_flags | bd.flags;
      if ((first_error_next == ST_OK) && (bd.err != ST_OK)) begin
        first_error_next = bd.err;
      end
      if (body_second) begin
        r1 = make_item(b, bd.part);
      end else begin
        r0 = make_item(b, bd.part);
        n  = 2'd1;
      end
    end

    if (fin) begin
      if (first_error_next == ST_OK) begin
        if (in_body(phase_next) && (escape_pending_next != 2'd0) && strict_mode) begin
          first_error_next = err_of(phase_next);
        end else if (phase_next == PH_SCHEME) begin
          first_error_next = ST_NO_COLON;
        end
      end
    end

    // tag the last result of this byte, and of the URI
    if (n == 2'd2) begin
      r1.run_last = 1'b1;
      if (fin) begin
        r1.uri_done      = 1'b1;
        r1.status        = first_error_next;
        r1.has_authority = part_flags_next[0];
        r1.has_query     = part_flags_next[1];
        r1.has_fragment  = part_flags_next[2];
      end
    end else if (n == 2'd1) begin
      r0.run_last = 1'b1;
      if (fin) begin
        r0.uri_done      = 1'b1;
        r0.status        = first_error_next;
        r0.has_authority = part_flags_next[0];
        r0.has_query     = part_flags_next[1];
        r0.has_fragment  = part_flags_next[2];
      end
    end

    if (fin) begin
      phase_next          = PH_SCHEME;
      escape_pending_next = 2'd0;
      first_error_next    = ST_OK;
      scheme_seen_next    = 1'b0;
      part_flags_next     = '0;
    end

    res.count  = n;
    res.first  = r0;
    res.second = r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strict_mode <= 1'b1;
    end else if (cfg_write) begin
      strict_mode <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_SCHEME;
      escape_pending <= 2'd0;
      first_error    <= ST_OK;
      scheme_seen    <= 1'b0;
      part_flags     <= '0;
    end else if (advance) begin
      phase          <= phase_next;
      escape_pending <= escape_pending_next;
      first_error    <= first_error_next;
      scheme_seen    <= scheme_seen_next;
      part_flags     <= part_flags_next;
    end
  end

  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    advance && item.final_byte |=> (phase == PH_SCHEME) && (first_error == ST_OK) &&
                                    (part_flags == '0) && (escape_pending == 2'd0))
    else $error("state not cleared after final byte");

  a_silent_only_held: assert property (@(posedge clk) disable iff (rst)
    advance && (res.count == 2'd0) |=> (phase == PH_HELD))
    else $error("byte without result outside held slash");

  a_escape_only_body: assert property (@(posedge clk) disable iff (rst)
    (escape_pending != 2'd0) |-> in_body(phase))
    else $error("escape pending outside body phase");

  a_final_has_result: assert property (@(posedge clk) disable iff (rst)
    advance && item.final_byte |-> (res.count != 2'd0))
    else $error("final byte produced no result");

endmodule

@@ hw/rtl/ucs_result_fifo.sv @@
// Result queue: takes zero, one or two result items per cycle and delivers
// one per cycle while out_ready is high. Depends on ucs_pkg.
module ucs_result_fifo
  import ucs_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  res_pair_t push,
  output logic      room,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  out_item_t          mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count, count_next;
  logic [PTR_W-1:0]   wr_ptr_1;
  logic               pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign wr_ptr_1  = ptr_inc(wr_ptr);
  assign room      = (count <= CNT_W'(DEPTH - 2));
  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  assign pop       = out_valid && out_ready;
  assign count_next = count + CNT_W'(push.count) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr_1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push.count == 2'd1) begin
        wr_ptr <= wr_ptr_1;
      end else if (push.count == 2'd2) begin
        wr_ptr <= ptr_inc(wr_ptr_1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("result queue overflow");

  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |-> room)
    else $error("push without room");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (count == '0))
    else $error("queue not empty after reset");

endmodule

@@ hw/rtl/uri_component_splitter.sv @@
// Top level of the URI component splitter: input register, classifier and
// result queue. Depends on ucs_pkg, ucs_classifier and ucs_result_fifo.
//
//   channel  | signals                       | payload
//   ---------+-------------------------------+----------------------------
//   input    | in_valid / in_ready           | in_data  (in_item_t)
//   result   | out_valid / out_ready         | out_data (out_item_t)
//   config   | cfg_write                     | cfg_data (strict_mode)
//
// One byte is accepted per cycle while the queue has room; a byte after a
// held slash gives two result items, so the sustained rate is set by the
// result port at one item a cycle. Bytes pass the input register and queue.
// Reset clears the parse state, empties the result queue and sets strict_mode.
// A stalled result port fills the queue, then the input register, then drops
// in_ready.
module uri_component_splitter
  import ucs_pkg::*;
#(
  parameter int FIFO_DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_write,
  input  logic      cfg_data
);

  logic      ireg_valid;
  in_item_t  ireg;
  logic      room;
  logic      advance;
  res_pair_t res;
  res_pair_t push;

  assign advance  = ireg_valid && room;
  assign in_ready = !ireg_valid || advance;

  always_comb begin
    push = res;
    if (!advance) begin
      push.count = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ireg_valid <= 1'b0;
    end else if (in_ready) begin
      ireg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ireg <= in_data;
    end
  end

  ucs_classifier u_classifier (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .advance   (advance),
    .item      (ireg),
    .res       (res)
  );

  ucs_result_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_result_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for uri_component_splitter: random and directed URI byte
// streams, with a byte-level predictor of the part tags, status and part flags.
// Depends on ucs_pkg and the uri_component_splitter RTL.
module tb_top;
  import ucs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 300000;
  localparam int SETTLE_CYCLES = 8;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_write = 1'b0;
  logic      cfg_data = 1'b0;

  uri_component_splitter dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data)
  );

  in_item_t  byte_q[$];
  out_item_t tag_q[$];
  int        queued = 0;
  int        issued = 0;
  int        accepted = 0;
  int        mismatches = 0;
  int        cycles = 0;
  int        send_idle_pct = 30;
  int        recv_idle_pct = 53;

  // predictor state
  logic       strict_on;
  phase_t     ph;
  logic [1:0] esc_left;
  logic [2:0] first_err;
  logic       scheme_started;
  logic [2:0] seen_flags;
  int         produced;
  out_item_t  want;

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------- byte classes ----------------
  function automatic bit letter(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic bit numeral(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit hex_char(input logic [7:0] c);
    return numeral(c) || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
  endfunction

  function automatic bit scheme_char(input logic [7:0] c);
    return letter(c) || numeral(c) || c == "+" || c == "-" || c == ".";
  endfunction

  function automatic bit path_char(input logic [7:0] c);
    case (c)
      "-", ".", "_", CH_TILDE, "!", "$", "&", "'", "(", ")", "*", "+", ",", ";", "=",
      CH_COLON, CH_AT: return 1'b1;
      default: return letter(c) || numeral(c);
    endcase
  endfunction

  function automatic bit allowed(input logic [7:0] c, input phase_t p);
    if (p == PH_AUTH) return path_char(c);
    if (p == PH_PATH) return path_char(c) || c == CH_SLASH;
    return path_char(c) || c == CH_SLASH || c == CH_QMARK;
  endfunction

  function automatic logic [2:0] err_for(input phase_t p);
    case (p)
      PH_AUTH:  return ST_BAD_AUTH;
      PH_PATH:  return ST_BAD_PATH;
      PH_QUERY: return ST_BAD_QUERY;
      default:  return ST_BAD_FRAG;
    endcase
  endfunction

  function automatic logic [2:0] part_for(input phase_t p);
    case (p)
      PH_AUTH:  return PART_AUTH;
      PH_PATH:  return PART_PATH;
      PH_QUERY: return PART_QUERY;
      default:  return PART_FRAG;
    endcase
  endfunction

  // ---------------- predictor ----------------
  task automatic clear_parse();
    ph = PH_SCHEME;
    esc_left = 2'd0;
    first_err = ST_OK;
    scheme_started = 1'b0;
    seen_flags = '0;
  endtask

  task automatic note_err(input logic [2:0] code);
    if (first_err == ST_OK) first_err = code;
  endtask

  task automatic add_tag(input logic [7:0] b, input logic [2:0] part);
    out_item_t r;
    r = '0;
    r.out_byte = b;
    r.part_code = part;
    tag_q.insert(tag_q.size(), r);
    produced++;
  endtask

  task automatic body_char(input logic [7:0] b);
    bit ends;
    ends = (b == CH_HASH && ph != PH_FRAG) ||
           (b == CH_QMARK && (ph == PH_AUTH || ph == PH_PATH)) ||
           (b == CH_SLASH && ph == PH_AUTH);
    if (ends) begin
      // a delimiter cuts off an open escape
      if (esc_left != 2'd0 && strict_on) note_err(err_for(ph));
      esc_left = 2'd0;
      if (b == CH_SLASH) begin
        ph = PH_PATH;
        add_tag(b, PART_PATH);
      end else if (b == CH_QMARK) begin
        seen_flags |= FLAG_QUERY;
        ph = PH_QUERY;
        add_tag(b, PART_SEP);
      end else begin
        seen_flags |= FLAG_FRAG;
        ph = PH_FRAG;
        add_tag(b, PART_SEP);
      end
    end else begin
      if (esc_left != 2'd0) begin
        if (hex_char(b)) begin
          esc_left = esc_left - 2'd1;
        end else begin
          if (strict_on) note_err(err_for(ph));
          esc_left = 2'd0;
        end
      end else if (b == CH_PERCENT) begin
        esc_left = 2'd2;
      end else if (strict_on && !allowed(b, ph)) begin
        note_err(err_for(ph));
      end
      add_tag(b, part_for(ph));
    end
  endtask

  task automatic split_byte(input logic [7:0] b, input logic fin);
    out_item_t tail;
    produced = 0;
    case (ph)
      PH_SCHEME: begin
        if (b == CH_COLON) begin
          if (!scheme_started) note_err(ST_SCHEME_START);
          ph = PH_COLON;
          add_tag(b, PART_SEP);
        end else begin
          if (!scheme_started) begin
            if (!letter(b)) note_err(ST_SCHEME_START);
          end else if (!scheme_char(b)) begin
            note_err(ST_SCHEME_CHAR);
          end
          scheme_started = 1'b1;
          add_tag(b, PART_SCHEME);
        end
      end
      PH_COLON: begin
        // hold a lone slash to tell authority from path, unless the URI ends here
        if (b == CH_SLASH && !fin) begin
          ph = PH_HELD;
        end else begin
          ph = PH_PATH;
          body_char(b);
        end
      end
      PH_HELD: begin
        if (b == CH_SLASH) begin
          add_tag(CH_SLASH, PART_SEP);
          add_tag(b, PART_SEP);
          seen_flags |= FLAG_AUTH;
          ph = PH_AUTH;
        end else begin
          add_tag(CH_SLASH, PART_PATH);
          ph = PH_PATH;
          body_char(b);
        end
      end
      default: body_char(b);
    endcase

    if (fin) begin
      if (ph >= PH_AUTH && ph <= PH_FRAG && esc_left != 2'd0 && strict_on)
        note_err(err_for(ph));
      if (ph == PH_SCHEME) note_err(ST_NO_COLON);
    end
    if (produced != 0) begin
      tail = tag_q[$];
      tail.run_last = 1'b1;
      if (fin) begin
        tail.uri_done = 1'b1;
        tail.status = first_err;
        tail.has_authority = seen_flags[0];
        tail.has_query = seen_flags[1];
        tail.has_fragment = seen_flags[2];
      end
      tag_q[tag_q.size() - 1] = tail;
    end
    if (fin) clear_parse();
  endtask

  task automatic compare(input string name, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      mismatches++;
    end
  endtask

  // ---------------- driver ----------------
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (accepted == issued) begin
      if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data <= byte_q.pop_front();
        in_valid <= 1'b1;
        issued <= issued + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= !rst && ($urandom_range(99) >= recv_idle_pct);
  end

  // ---------------- monitor ----------------
  always @(posedge clk) begin
    if (rst) begin
      strict_on = 1'b1;
      clear_parse();
    end else begin
      if (cfg_write) strict_on = cfg_data;
      if (in_valid && in_ready) begin
        split_byte(in_data.text_byte, in_data.final_byte);
        accepted <= accepted + 1;
      end
      if (out_valid && out_ready) begin
        if (tag_q.size() == 0) begin
          $error("out_byte: no result expected, got %0d", out_data.out_byte);
          mismatches++;
        end else begin
          want = tag_q.pop_front();
          compare("out_byte", want.out_byte, out_data.out_byte);
          compare("part_code", want.part_code, out_data.part_code);
          compare("run_last", want.run_last, out_data.run_last);
          compare("uri_done", want.uri_done, out_data.uri_done);
          compare("status", want.status, out_data.status);
          compare("has_authority", want.has_authority, out_data.has_authority);
          compare("has_query", want.has_query, out_data.has_query);
          compare("has_fragment", want.has_fragment, out_data.has_fragment);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  task automatic push_byte(input logic [7:0] b, input logic fin);
    in_item_t it;
    it.text_byte = b;
    it.final_byte = fin;
    byte_q.insert(byte_q.size(), it);
    queued++;
  endtask

  task automatic queue_text(input string s, input bit ends_uri);
    for (int i = 0; i < s.len(); i++)
      push_byte(s[i], ends_uri && i == s.len() - 1);
  endtask

  function automatic logic [7:0] pick(input string s);
    return s[$urandom_range(s.len() - 1)];
  endfunction

  task automatic append_byte(ref logic [7:0] u[$], input logic [7:0] c);
    u.insert(u.size(), c);
  endtask

  task automatic add_text(ref logic [7:0] u[$], input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 10) begin
        append_byte(u, CH_PERCENT);
        append_byte(u, pick("0123456789abcdefABCDEF"));
        // now and then break the escape
        append_byte(u, ($urandom_range(9) == 0) ? pick("gZ%/") : pick("0123456789aF"));
      end else if (r < 80) begin
        append_byte(u, pick("aZq09-._~!$&'()*+,;=:@"));
      end else if (r < 88) begin
        append_byte(u, CH_SLASH);
      end else if (r < 95) begin
        append_byte(u, 8'($urandom_range(255)));
      end else begin
        append_byte(u, pick("?#%"));
      end
    end
  endtask

  task automatic queue_random_uri();
    logic [7:0] u[$];
    int kind;
    int n;
    kind = $urandom_range(99);
    n = $urandom_range(1, 5);
    append_byte(u, ($urandom_range(19) == 0) ? 8'($urandom_range(255)) : pick("aqZxM"));
    for (int i = 1; i < n; i++)
      append_byte(u, ($urandom_range(14) == 0) ? 8'($urandom_range(255)) :
                     pick("azAZ09+-."));
    if (kind < 80) begin
      append_byte(u, CH_COLON);
      if ($urandom_range(1)) begin
        append_byte(u, CH_SLASH);
        append_byte(u, CH_SLASH);
        add_text(u, $urandom_range(0, 6));
      end
      case ($urandom_range(3))
        0: ;
        1: begin
          append_byte(u, CH_SLASH);
          add_text(u, $urandom_range(0, 6));
        end
        2: add_text(u, $urandom_range(1, 6));
        default: begin
          append_byte(u, CH_SLASH);
          add_text(u, $urandom_range(0, 4));
          append_byte(u, CH_SLASH);
          add_text(u, $urandom_range(0, 4));
        end
      endcase
      if ($urandom_range(2) == 0) begin
        append_byte(u, CH_QMARK);
        add_text(u, $urandom_range(0, 6));
      end
      if ($urandom_range(2) == 0) begin
        append_byte(u, CH_HASH);
        add_text(u, $urandom_range(0, 6));
      end
    end else if (kind < 90) begin
      // raw noise, colon optional
      u.delete();
      n = $urandom_range(1, 10);
      for (int i = 0; i < n; i++)
        append_byte(u, $urandom_range(4) < 2 ? pick(":/?#%") : 8'($urandom_range(255)));
    end else begin
      // short tails around the held slash
      append_byte(u, CH_COLON);
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++)
        append_byte(u, pick("//?#%a"));
    end
    for (int i = 0; i < u.size(); i++)
      push_byte(u[i], i == u.size() - 1);
  endtask

  // Hold off until every queued item is in and every result is out.
  task automatic settle();
    @(posedge clk);
    while (byte_q.size() != 0 || in_valid || accepted != issued || tag_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_strict(input logic v);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic run_segment(input int s_idle, input int r_idle, input logic strict,
                             input int n_bytes);
    int stop_at;
    settle();
    set_strict(strict);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    stop_at = queued + n_bytes;
    while (queued < stop_at) queue_random_uri();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    set_strict(1'b1);

    queue_text(":", 1);          // empty scheme
    queue_text("1", 1);          // bad scheme start, no colon
    queue_text("a~", 1);         // bad scheme char, no colon
    queue_text("s:/", 1);        // final slash after colon is not held
    queue_text("s://@/%?", 1);   // authority, escape cut by a delimiter
    queue_text("s:/x?#%", 1);    // held slash into path, escape cut by the end
    // switch mode in the middle of a URI
    queue_text("p:a", 0);
    settle();
    set_strict(1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b1);

    run_segment(30, 53, 1'b0, 250);
    run_segment(53, 30, 1'b1, 250);
    run_segment(0, 0, 1'b0, 120);
    run_segment(0, 0, 1'b1, 130);

    settle();
    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/ucs_pkg.sv
hw/rtl/ucs_classifier.sv
hw/rtl/ucs_result_fifo.sv
hw/rtl/uri_component_splitter.sv
tb/tb_top.sv
